### rtl/bce_pkg.sv
// ---------------------------------------------------------------------------
// bce_pkg
// shared types and constants of the bezier curve evaluator
// ---------------------------------------------------------------------------
package bce_pkg;

   localparam int MAX_POINTS_DEF = 16;
   localparam int COORD_W        = 32;
   localparam int T_W            = 18;
   localparam int TQ_W           = 17;
   localparam int FRAC30_W       = 31;
   localparam int MUL_W          = 64;
   localparam int PROD_W         = 2 * MUL_W;
   localparam int CHUNK_W        = 16;
   localparam int RES_W          = 48;
   localparam int TOTAL_W        = 5;
   localparam int Q_DEPTH        = 2;

   localparam logic [TQ_W-1:0]     ONE_T = TQ_W'(65536);
   localparam logic [FRAC30_W-1:0] ONE30 = FRAC30_W'(32'h4000_0000);

   typedef enum logic [1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_APPEND = 2'd1,
      CMD_EVAL   = 2'd2,
      CMD_NOP    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK          = 2'd0,
      STATUS_UNDER_TWO   = 2'd1,
      STATUS_UNDER_THREE = 2'd2,
      STATUS_FULL        = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SW_RD,
      ST_SW_WR,
      ST_PU_MUL,
      ST_T_RD,
      ST_T_CAP,
      ST_M_Q,
      ST_M_B,
      ST_M_V,
      ST_M_T,
      ST_FIN_MUL,
      ST_FIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      cmd_type                 cmd;
      logic [COORD_W-1:0]      x;
      logic [COORD_W-1:0]      y;
      logic [TQ_W-1:0]         tq;
   } item_type;

   typedef struct packed {
      logic             start;
      logic [MUL_W-1:0] a;
      logic [MUL_W-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [PROD_W-1:0] prod;
   } mul_rsp_type;

endpackage

### rtl/bce_front.sv
// ---------------------------------------------------------------------------
// bce_front
// accepts command beats, decodes the command, clamps t and queues the item
// ---------------------------------------------------------------------------
module bce_front
   import bce_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_cmd,
   input  logic signed [31:0]    req_coord_x,
   input  logic signed [31:0]    req_coord_y,
   input  logic signed [T_W-1:0] req_param_t,
   output logic                  fifo_avail,
   output item_type              fifo_head,
   input  logic                  fifo_pop
);

   localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int CW = $clog2(Q_DEPTH + 1);

   item_type          q_mem [Q_DEPTH];
   logic [PW-1:0]     wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              push;
   item_type          item;

   always_comb begin
      item.cmd = cmd_type'(req_cmd);
      item.x   = req_coord_x;
      item.y   = req_coord_y;
      if (req_param_t[T_W-1]) begin
         item.tq = '0;
      end else if (req_param_t > $signed({1'b0, ONE_T})) begin
         item.tq = ONE_T;
      end else begin
         item.tq = req_param_t[TQ_W-1:0];
      end
   end

   assign req_ready  = (cnt_ff != CW'(Q_DEPTH));
   assign push       = req_valid && req_ready;
   assign fifo_avail = (cnt_ff != '0);
   assign fifo_head  = q_mem[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PW'(Q_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (fifo_pop) begin
         rd_in = (rd_ff == PW'(Q_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !fifo_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!push && fifo_pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem[wr_ff] <= item;
      end
   end

endmodule

### rtl/bce_mul.sv
// ---------------------------------------------------------------------------
// bce_mul
// shared unsigned multiplier, 64 x 64 bits, one 16-bit digit of b per cycle
// ---------------------------------------------------------------------------
module bce_mul
   import bce_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  mul_req_type mreq,
   output mul_rsp_type mrsp
);

   localparam int KW = $clog2(MUL_W / CHUNK_W);

   logic [MUL_W-1:0]         a_ff, a_in, b_ff, b_in;
   logic [PROD_W-1:0]        prod_ff, prod_in;
   logic [KW-1:0]            k_ff, k_in;
   logic                     busy_ff, busy_in, done_ff, done_in;
   logic [MUL_W+CHUNK_W-1:0] part;

   assign part = a_ff * b_ff[CHUNK_W-1:0];

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      prod_in = prod_ff;
      k_in    = k_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (mreq.start) begin
         a_in    = mreq.a;
         b_in    = mreq.b;
         prod_in = '0;
         k_in    = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         prod_in = prod_ff + (PROD_W'(part) << {k_ff, 4'b0000});
         b_in    = b_ff >> CHUNK_W;
         k_in    = k_ff + 1'b1;
         if (k_ff == '1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         k_ff    <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         k_ff    <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      prod_ff <= prod_in;
   end

   assign mrsp.busy = busy_ff;
   assign mrsp.done = done_ff;
   assign mrsp.prod = prod_ff;

endmodule

### rtl/bce_back.sv
// ---------------------------------------------------------------------------
// bce_back
// control point store, binomial row, power table and the evaluation sequencer
// ---------------------------------------------------------------------------
module bce_back
   import bce_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    fifo_avail,
   input  item_type                fifo_head,
   output logic                    fifo_pop,
   output mul_req_type             mreq,
   input  mul_rsp_type             mrsp,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [1:0]              rsp_status,
   output logic signed [RES_W-1:0] rsp_point_x,
   output logic signed [RES_W-1:0] rsp_point_y,
   output logic signed [RES_W-1:0] rsp_slope_x,
   output logic signed [RES_W-1:0] rsp_slope_y,
   output logic signed [RES_W-1:0] rsp_bend_x,
   output logic signed [RES_W-1:0] rsp_bend_y,
   output logic [TOTAL_W-1:0]      rsp_point_total
);

   localparam int IW   = $clog2(MAX_POINTS);
   localparam int CNTW = $clog2(MAX_POINTS + 1);
   localparam int BW   = MAX_POINTS;
   localparam int VW   = COORD_W + 3;

   function automatic logic signed [63:0] add_sat(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) begin
         return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end
      return s[63:0];
   endfunction

   function automatic logic signed [63:0] sat_apply(input logic [PROD_W-1:0] p,
                                                    input logic neg);
      if (|p[PROD_W-1:63]) begin
         return neg ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end
      return neg ? -$signed(p[63:0]) : $signed(p[63:0]);
   endfunction

   function automatic logic signed [RES_W-1:0] finish(input logic signed [63:0] acc);
      logic [63:0] mag;
      logic [64:0] s;
      logic [39:0] r;
      mag = acc[63] ? 64'(-acc) : 64'(acc);
      s   = {1'b0, mag} + 65'd8388608;
      r   = s[63:24];
      return acc[63] ? -$signed({8'd0, r}) : $signed({8'd0, r});
   endfunction

   // storage
   logic [63:0]          st_mem  [MAX_POINTS];
   logic [BW-1:0]        row_mem [MAX_POINTS];
   logic [FRAC30_W-1:0]  pu_mem  [MAX_POINTS];
   logic [63:0]          st_rd_ff;
   logic [BW-1:0]        row_rd_ff;
   logic [FRAC30_W-1:0]  pu_rd_ff;
   logic                 st_we, st_re, row_we, row_re, pu_we, pu_re;
   logic [IW-1:0]        st_wa, st_ra, row_wa, row_ra, pu_wa, pu_ra;
   logic [63:0]          st_wd;
   logic [BW-1:0]        row_wd;
   logic [FRAC30_W-1:0]  pu_wd;

   state_type                  state_ff, state_in;
   logic [CNTW-1:0]            count_ff, count_in, idx_ff, idx_in;
   logic [1:0]                 sub_ff, sub_in, order_ff, order_in;
   logic                       axis_ff, axis_in;
   logic [TQ_W-1:0]            tq_ff, tq_in;
   logic [BW-1:0]              prev1_ff, prev1_in, prev2_ff, prev2_in, curc_ff, curc_in;
   logic [FRAC30_W-1:0]        pt_ff, pt_in;
   logic signed [VW-1:0]       v_ff, v_in;
   logic signed [63:0]         acc_ff, acc_in;
   logic signed [RES_W-1:0]    res_ff [6];
   logic signed [RES_W-1:0]    res_in [6];
   status_type                 status_ff, status_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [1:0]                 rsp_status_ff;
   logic signed [RES_W-1:0]    rsp_res_ff [6];
   logic [TOTAL_W-1:0]         rsp_total_ff;

   logic [CNTW-1:0]            n_w, deg;
   logic [1:0]                 max_order;
   logic [TQ_W-1:0]            uq, uq_head;
   logic [PROD_W:0]            rnd16, rnd29, rnd6;
   logic signed [VW-1:0]       coord, term;
   logic [VW-1:0]              v_mag;
   logic [BW-1:0]              c1, c2, old;
   logic [63:0]                acc_mag;
   logic [2*CNTW-1:0]          mscale;
   logic [2:0]                 slot;

   assign n_w       = count_ff - 1'b1;
   assign deg       = n_w - CNTW'(order_ff);
   assign max_order = (n_w >= CNTW'(2)) ? 2'd2 : 2'd1;
   assign uq        = ONE_T - tq_ff;
   assign uq_head   = ONE_T - fifo_head.tq;
   assign rnd16     = {1'b0, mrsp.prod} + (PROD_W+1)'(32768);
   assign rnd29     = {1'b0, mrsp.prod} + (PROD_W+1)'(32'h2000_0000);
   assign rnd6      = {1'b0, mrsp.prod} + (PROD_W+1)'(32);
   assign coord     = axis_ff ? VW'($signed(st_rd_ff[63:32]))
                              : VW'($signed(st_rd_ff[31:0]));
   assign v_mag     = v_ff[VW-1] ? VW'(-v_ff) : VW'(v_ff);
   assign c1        = row_rd_ff - prev1_ff;
   assign c2        = c1 - prev2_ff;
   assign old       = (idx_ff == count_ff) ? '0 : row_rd_ff;
   assign acc_mag   = acc_ff[63] ? 64'(-acc_ff) : 64'(acc_ff);
   assign mscale    = (order_ff == 2'd1) ? (2*CNTW)'(n_w)
                                         : (2*CNTW)'(n_w * (n_w - 1'b1));
   assign slot      = {order_ff, axis_ff};

   always_comb begin
      if (order_ff == 2'd0) begin
         term = coord;
      end else if (order_ff == 2'd1) begin
         term = (sub_ff == 2'd0) ? -coord : coord;
      end else begin
         term = (sub_ff == 2'd1) ? -(coord <<< 1) : coord;
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      sub_in       = sub_ff;
      order_in     = order_ff;
      axis_in      = axis_ff;
      tq_in        = tq_ff;
      prev1_in     = prev1_ff;
      prev2_in     = prev2_ff;
      curc_in      = curc_ff;
      pt_in        = pt_ff;
      v_in         = v_ff;
      acc_in       = acc_ff;
      status_in    = status_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      fifo_pop     = 1'b0;
      mreq         = '0;
      st_we  = 1'b0; st_wa  = '0; st_wd  = '0; st_re  = 1'b0; st_ra  = '0;
      row_we = 1'b0; row_wa = '0; row_wd = '0; row_re = 1'b0; row_ra = '0;
      pu_we  = 1'b0; pu_wa  = '0; pu_wd  = '0; pu_re  = 1'b0; pu_ra  = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (fifo_avail) begin
               fifo_pop  = 1'b1;
               status_in = STATUS_OK;
               tq_in     = fifo_head.tq;
               for (int k = 0; k < 6; k++) begin
                  res_in[k] = '0;
               end
               state_in = ST_DONE;
               unique case (fifo_head.cmd)
                  CMD_CLEAR: count_in = '0;
                  CMD_APPEND: begin
                     if (count_ff == CNTW'(MAX_POINTS)) begin
                        status_in = STATUS_FULL;
                     end else begin
                        st_we = 1'b1;
                        st_wa = count_ff[IW-1:0];
                        st_wd = {fifo_head.y, fifo_head.x};
                        if (count_ff == '0) begin
                           row_we   = 1'b1;
                           row_wa   = '0;
                           row_wd   = BW'(1);
                           count_in = CNTW'(1);
                        end else begin
                           idx_in   = '0;
                           prev1_in = '0;
                           state_in = ST_SW_RD;
                        end
                     end
                  end
                  CMD_EVAL: begin
                     if (count_ff < CNTW'(2)) begin
                        status_in = STATUS_UNDER_TWO;
                     end else begin
                        pu_we      = 1'b1;
                        pu_wa      = '0;
                        pu_wd      = ONE30;
                        idx_in     = CNTW'(1);
                        order_in   = 2'd0;
                        axis_in    = 1'b0;
                        mreq.start = 1'b1;
                        mreq.a     = MUL_W'(ONE30);
                        mreq.b     = MUL_W'(uq_head);
                        state_in   = ST_PU_MUL;
                     end
                  end
                  CMD_NOP: state_in = ST_DONE;
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_SW_RD: begin
            row_re   = (idx_ff != count_ff);
            row_ra   = idx_ff[IW-1:0];
            state_in = ST_SW_WR;
         end
         ST_SW_WR: begin
            row_we   = 1'b1;
            row_wa   = idx_ff[IW-1:0];
            row_wd   = old + prev1_ff;
            prev1_in = old;
            if (idx_ff == count_ff) begin
               count_in = count_ff + 1'b1;
               state_in = ST_DONE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_SW_RD;
            end
         end
         ST_PU_MUL: begin
            if (mrsp.done) begin
               pu_we = 1'b1;
               pu_wa = idx_ff[IW-1:0];
               pu_wd = rnd16[FRAC30_W+15:16];
               if (idx_ff == n_w) begin
                  idx_in   = '0;
                  sub_in   = '0;
                  prev1_in = '0;
                  prev2_in = '0;
                  acc_in   = '0;
                  pt_in    = ONE30;
                  state_in = ST_T_RD;
               end else begin
                  idx_in     = idx_ff + 1'b1;
                  mreq.start = 1'b1;
                  mreq.a     = MUL_W'(rnd16[FRAC30_W+15:16]);
                  mreq.b     = MUL_W'(uq);
                  state_in   = ST_PU_MUL;
               end
            end
         end
         ST_T_RD: begin
            st_re = 1'b1;
            st_ra = IW'(idx_ff + CNTW'(sub_ff));
            if (sub_ff == 2'd0) begin
               row_re = 1'b1;
               row_ra = idx_ff[IW-1:0];
               pu_re  = 1'b1;
               pu_ra  = IW'(deg - idx_ff);
            end
            state_in = ST_T_CAP;
         end
         ST_T_CAP: begin
            v_in = ((sub_ff == 2'd0) ? '0 : v_ff) + term;
            if (sub_ff == order_ff) begin
               curc_in    = (order_ff == 2'd0) ? row_rd_ff :
                            (order_ff == 2'd1) ? c1 : c2;
               prev1_in   = c1;
               prev2_in   = c2;
               mreq.start = 1'b1;
               mreq.a     = MUL_W'(pt_ff);
               mreq.b     = MUL_W'(pu_rd_ff);
               state_in   = ST_M_Q;
            end else begin
               sub_in   = sub_ff + 1'b1;
               state_in = ST_T_RD;
            end
         end
         ST_M_Q: begin
            if (mrsp.done) begin
               mreq.start = 1'b1;
               mreq.a     = MUL_W'(curc_ff);
               mreq.b     = MUL_W'(rnd29[FRAC30_W+29:30]);
               state_in   = ST_M_B;
            end
         end
         ST_M_B: begin
            if (mrsp.done) begin
               mreq.start = 1'b1;
               mreq.a     = MUL_W'(v_mag);
               mreq.b     = rnd6[MUL_W+5:6];
               state_in   = ST_M_V;
            end
         end
         ST_M_V: begin
            if (mrsp.done) begin
               acc_in     = add_sat(acc_ff, sat_apply(mrsp.prod, v_ff[VW-1]));
               mreq.start = 1'b1;
               mreq.a     = MUL_W'(pt_ff);
               mreq.b     = MUL_W'(tq_ff);
               state_in   = ST_M_T;
            end
         end
         ST_M_T: begin
            if (mrsp.done) begin
               pt_in = rnd16[FRAC30_W+15:16];
               if (idx_ff == deg) begin
                  if (order_ff == 2'd0) begin
                     state_in = ST_FIN;
                  end else begin
                     mreq.start = 1'b1;
                     mreq.a     = acc_mag;
                     mreq.b     = MUL_W'(mscale);
                     state_in   = ST_FIN_MUL;
                  end
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  sub_in   = '0;
                  state_in = ST_T_RD;
               end
            end
         end
         ST_FIN_MUL: begin
            if (mrsp.done) begin
               acc_in   = sat_apply(mrsp.prod, acc_ff[63]);
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            for (int k = 0; k < 6; k++) begin
               if (slot == 3'(k)) begin
                  res_in[k] = finish(acc_ff);
               end
            end
            idx_in   = '0;
            sub_in   = '0;
            prev1_in = '0;
            prev2_in = '0;
            acc_in   = '0;
            pt_in    = ONE30;
            state_in = ST_T_RD;
            if (!axis_ff) begin
               axis_in = 1'b1;
            end else begin
               axis_in = 1'b0;
               if (order_ff == max_order) begin
                  status_in = (n_w < CNTW'(2)) ? STATUS_UNDER_THREE : STATUS_OK;
                  state_in  = ST_DONE;
               end else begin
                  order_in = order_ff + 1'b1;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      sub_ff    <= sub_in;
      order_ff  <= order_in;
      axis_ff   <= axis_in;
      tq_ff     <= tq_in;
      prev1_ff  <= prev1_in;
      prev2_ff  <= prev2_in;
      curc_ff   <= curc_in;
      pt_ff     <= pt_in;
      v_ff      <= v_in;
      acc_ff    <= acc_in;
      status_ff <= status_in;
      res_ff    <= res_in;
      if (state_ff == ST_DONE && (!rsp_valid_ff || rsp_ready)) begin
         rsp_status_ff <= status_ff;
         rsp_res_ff    <= res_ff;
         rsp_total_ff  <= TOTAL_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (st_we) begin
         st_mem[st_wa] <= st_wd;
      end
      if (st_re) begin
         st_rd_ff <= st_mem[st_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (row_we) begin
         row_mem[row_wa] <= row_wd;
      end
      if (row_re) begin
         row_rd_ff <= row_mem[row_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (pu_we) begin
         pu_mem[pu_wa] <= pu_wd;
      end
      if (pu_re) begin
         pu_rd_ff <= pu_mem[pu_ra];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_point_x     = rsp_res_ff[0];
   assign rsp_point_y     = rsp_res_ff[1];
   assign rsp_slope_x     = rsp_res_ff[2];
   assign rsp_slope_y     = rsp_res_ff[3];
   assign rsp_bend_x      = rsp_res_ff[4];
   assign rsp_bend_y      = rsp_res_ff[5];
   assign rsp_point_total = rsp_total_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNTW'(MAX_POINTS))
      else $error("point count beyond store depth");

   a_mul_free: assert property (@(posedge clock) disable iff (reset)
      mreq.start |-> (!mrsp.busy || mrsp.done))
      else $error("multiplier started while busy");

   a_mul_owner: assert property (@(posedge clock) disable iff (reset)
      mrsp.done |-> (state_ff == ST_PU_MUL || state_ff == ST_M_Q || state_ff == ST_M_B ||
                     state_ff == ST_M_V || state_ff == ST_M_T || state_ff == ST_FIN_MUL))
      else $error("multiplier result with no waiting step");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("result beat raised outside completion");
`endif

endmodule

### rtl/bezier_curve_evaluator.sv
// ---------------------------------------------------------------------------
// bezier_curve_evaluator
// 2d bezier curve point, slope and bend over a store of control points
// ---------------------------------------------------------------------------
// req channel: one beat per command (clear, append point, evaluate at t, no-op).
// rsp channel: exactly one beat per command, in command order.
// a two-entry queue decouples command intake from the sequencer, and the
// result register lets the next command start while a result waits.
// clear and no-op go straight to the result step; append for n stored
// points runs the sweep that updates the binomial row.
// evaluate builds the power table, then works term by term over the
// point, slope and bend sums of both axes, about 6*n terms in all;
// every step waits on the one shared multiplier.
// reset empties the store, the queue and the result register.
// when the rsp side stalls the result holds, the sequencer finishes at
// most one more command and the queue then fills and drops req_ready.
// ---------------------------------------------------------------------------
module bezier_curve_evaluator
   import bce_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [1:0]              req_cmd,
   input  logic signed [31:0]      req_coord_x,
   input  logic signed [31:0]      req_coord_y,
   input  logic signed [T_W-1:0]   req_param_t,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [1:0]              rsp_status,
   output logic signed [RES_W-1:0] rsp_point_x,
   output logic signed [RES_W-1:0] rsp_point_y,
   output logic signed [RES_W-1:0] rsp_slope_x,
   output logic signed [RES_W-1:0] rsp_slope_y,
   output logic signed [RES_W-1:0] rsp_bend_x,
   output logic signed [RES_W-1:0] rsp_bend_y,
   output logic [TOTAL_W-1:0]      rsp_point_total
);

   logic        fifo_avail, fifo_pop;
   item_type    fifo_head;
   mul_req_type mreq;
   mul_rsp_type mrsp;

   bce_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_cmd     (req_cmd),
      .req_coord_x (req_coord_x),
      .req_coord_y (req_coord_y),
      .req_param_t (req_param_t),
      .fifo_avail  (fifo_avail),
      .fifo_head   (fifo_head),
      .fifo_pop    (fifo_pop)
   );

   bce_mul u_mul (
      .clock (clock),
      .reset (reset),
      .mreq  (mreq),
      .mrsp  (mrsp)
   );

   bce_back #(.MAX_POINTS(MAX_POINTS)) u_back (
      .clock           (clock),
      .reset           (reset),
      .fifo_avail      (fifo_avail),
      .fifo_head       (fifo_head),
      .fifo_pop        (fifo_pop),
      .mreq            (mreq),
      .mrsp            (mrsp),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_point_x     (rsp_point_x),
      .rsp_point_y     (rsp_point_y),
      .rsp_slope_x     (rsp_slope_x),
      .rsp_slope_y     (rsp_slope_y),
      .rsp_bend_x      (rsp_bend_x),
      .rsp_bend_y      (rsp_bend_y),
      .rsp_point_total (rsp_point_total)
   );

endmodule

### tb/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// randomized check of the bezier curve evaluator against a built-in predictor
// ---------------------------------------------------------------------------
// commands are queued by an initial block and sent by a clocked driver with
// random gaps; a clocked monitor with random stalls compares every rsp beat
// field by field with the oldest predicted result.
// ---------------------------------------------------------------------------
module tb_top
   import bce_pkg::*;
;

   localparam int NPTS = MAX_POINTS_DEF;
   localparam longint MAX48 = 64'sd140737488355327;
   localparam longint MIN48 = -64'sd140737488355328;
   localparam longint CYCLE_LIMIT = 10000000;

   typedef struct {
      logic [1:0]         cmd;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic [T_W-1:0]     t;
   } cmd_beat_type;

   typedef struct {
      logic [1:0]            status;
      logic [RES_W-1:0]      curve [6];
      logic [TOTAL_W-1:0]    total;
   } curve_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_cmd = CMD_NOP;
   logic signed [31:0] req_coord_x = '0;
   logic signed [31:0] req_coord_y = '0;
   logic signed [T_W-1:0] req_param_t = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [1:0] rsp_status;
   logic signed [RES_W-1:0] rsp_point_x, rsp_point_y, rsp_slope_x, rsp_slope_y;
   logic signed [RES_W-1:0] rsp_bend_x, rsp_bend_y;
   logic [TOTAL_W-1:0] rsp_point_total;

   cmd_beat_type     pending_cmds[$];
   curve_result_type expected_curves[$];
   longint           point_store [NPTS];
   int               point_count = 0;
   int               mismatches = 0;
   longint           cycles = 0;
   int               hold_request = 0;

   always #1 clock = ~clock;

   bezier_curve_evaluator dut (.*);

   function automatic longint sat_add(longint a, longint b);
      longint s;
      s = a + b;
      if (a > 0 && b > 0 && s < 0) return 64'h7fffffffffffffff;
      if (a < 0 && b < 0 && s >= 0) return 64'h8000000000000000;
      return s;
   endfunction

   function automatic longint sat_mul(longint a, longint unsigned b);
      longint unsigned mag;
      if (a == 0 || b == 0) return 0;
      mag = (a < 0) ? -a : a;
      if (b > 64'h7fffffffffffffff / mag)
         return (a < 0) ? 64'h8000000000000000 : 64'h7fffffffffffffff;
      return (a < 0) ? -longint'(mag * b) : longint'(mag * b);
   endfunction

   function automatic longint round_q24(longint acc);
      longint unsigned mag;
      longint r;
      mag = (acc < 0) ? -acc : acc;
      r = longint'((mag + (64'd1 << 23)) >> 24);
      if (acc < 0) r = -r;
      if (r > MAX48) r = MAX48;
      if (r < MIN48) r = MIN48;
      return r;
   endfunction

   function automatic longint unsigned choose(int n, int k);
      longint unsigned c;
      c = 1;
      if (k > n) return 0;
      if (k > n - k) k = n - k;
      for (int i = 0; i < k; i++) c = c * (n - i) / (i + 1);
      return c;
   endfunction

   function automatic longint unsigned pow_q30(longint unsigned v, int e);
      longint unsigned p;
      p = 64'd1 << 30;
      repeat (e) p = (p * v + 32768) >> 16;
      return p;
   endfunction

   function automatic longint unsigned bern_weight(int deg, int i, longint unsigned tq);
      longint unsigned q;
      q = (pow_q30(tq, i) * pow_q30(65536 - tq, deg - i) + (64'd1 << 29)) >> 30;
      return (choose(deg, i) * q + 32) >> 6;
   endfunction

   function automatic longint coord_of(int i, int axis);
      if (i >= NPTS) return 0;
      return axis ? longint'(signed'(point_store[i][63:32]))
                  : longint'(signed'(point_store[i][31:0]));
   endfunction

   function automatic longint bern_sum(int deg, int order, int axis, longint unsigned tq);
      longint acc, v;
      acc = 0;
      for (int i = 0; i <= deg; i++) begin
         if (order == 0) v = coord_of(i, axis);
         else if (order == 1) v = coord_of(i + 1, axis) - coord_of(i, axis);
         else v = coord_of(i + 2, axis) - 2 * coord_of(i + 1, axis) + coord_of(i, axis);
         acc = sat_add(acc, sat_mul(v, bern_weight(deg, i, tq)));
      end
      return acc;
   endfunction

   function automatic curve_result_type predict_curve(cmd_beat_type b);
      curve_result_type r;
      longint t;
      int n;
      r.status = STATUS_OK;
      for (int j = 0; j < 6; j++) r.curve[j] = '0;
      case (b.cmd)
         CMD_CLEAR: begin
            point_count = 0;
         end
         CMD_APPEND: begin
            if (point_count < NPTS) begin
               point_store[point_count] = {b.y, b.x};
               point_count++;
            end else r.status = STATUS_FULL;
         end
         CMD_EVAL: begin
            if (point_count < 2) r.status = STATUS_UNDER_TWO;
            else begin
               t = longint'(signed'(b.t));
               if (t < 0) t = 0;
               if (t > 65536) t = 65536;
               n = point_count - 1;
               for (int ax = 0; ax < 2; ax++) begin
                  r.curve[ax] = RES_W'(round_q24(bern_sum(n, 0, ax, t)));
                  r.curve[2+ax] = RES_W'(round_q24(sat_mul(bern_sum(n - 1, 1, ax, t), n)));
                  if (n >= 2)
                     r.curve[4+ax] = RES_W'(round_q24(sat_mul(bern_sum(n - 2, 2, ax, t),
                                                              n * (n - 1))));
               end
               if (n < 2) r.status = STATUS_UNDER_THREE;
            end
         end
         default: ;
      endcase
      r.total = point_count[TOTAL_W-1:0];
      return r;
   endfunction

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return 32'($signed($urandom_range(0, 131072)) - 65536);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [T_W-1:0] rand_t();
      case ($urandom_range(0, 7))
         0: return T_W'(0);
         1: return T_W'(65536);
         2: return T_W'($urandom);
         default: return T_W'($urandom_range(0, 65536));
      endcase
   endfunction

   task automatic queue_cmd(logic [1:0] c, logic [31:0] x, logic [31:0] y, logic [T_W-1:0] t);
      cmd_beat_type b;
      b.cmd = c; b.x = x; b.y = y; b.t = t;
      pending_cmds.insert(pending_cmds.size(), b);
   endtask

   // driver
   int send_gap;
   always @(posedge clock) begin
      cmd_beat_type b;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else if (req_valid && !req_ready) begin
      end else begin
         if (req_valid) begin
            b.cmd = req_cmd; b.x = req_coord_x; b.y = req_coord_y; b.t = req_param_t;
            expected_curves.insert(expected_curves.size(), predict_curve(b));
         end
         if (send_gap > 0 || pending_cmds.size() == 0 || pending_cmds[0].cmd === 2'bxx) begin
            req_valid <= 1'b0;
            if (send_gap > 0) send_gap <= send_gap - 1;
         end else begin
            b = pending_cmds.pop_front();
            req_valid   <= 1'b1;
            req_cmd     <= b.cmd;
            req_coord_x <= b.x;
            req_coord_y <= b.y;
            req_param_t <= b.t;
            send_gap    <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14);
         end
      end
   end

   // monitor
   int stall_left;
   bit hold_taken = 1'b0;
   always @(posedge clock) begin
      curve_result_type e;
      logic [RES_W-1:0] got [6];
      bit bad;
      int idle;
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_point_x, rsp_point_y, rsp_slope_x, rsp_slope_y,
                    rsp_bend_x, rsp_bend_y};
            if (expected_curves.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected rsp beat status %0d", rsp_status);
            end else begin
               e = expected_curves.pop_front();
               bad = (e.status !== rsp_status) || (e.total !== rsp_point_total);
               for (int j = 0; j < 6; j++) if (e.curve[j] !== got[j]) bad = 1;
               if (bad) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("mismatch: exp status %0d total %0d, got status %0d total %0d",
                              e.status, e.total, rsp_status, rsp_point_total);
                     for (int j = 0; j < 6; j++)
                        $display("  field %0d exp %h got %h", j, e.curve[j], got[j]);
                  end
               end
            end
         end
         if (hold_request > 0 && !hold_taken) begin
            rsp_ready  <= 1'b0;
            stall_left <= hold_request;
            hold_taken <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_ready  <= 1'b0;
            stall_left <= stall_left - 1;
         end else if (!rsp_ready) begin
            rsp_ready <= 1'b1;
         end else if (rsp_valid) begin
            idle = $urandom_range(0, 14);
            if (idle > 0) begin
               rsp_ready  <= 1'b0;
               stall_left <= idle - 1;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   task automatic wait_drained();
      while (pending_cmds.size() != 0 || req_valid || expected_curves.size() != 0)
         @(posedge clock);
   endtask

   task automatic queue_points(int k);
      repeat (k) queue_cmd(CMD_APPEND, rand_coord(), rand_coord(), '0);
   endtask

   initial begin
      int sent;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      // directed
      queue_cmd(CMD_EVAL, '0, '0, T_W'(32768));
      queue_cmd(CMD_APPEND, 32'h7fffffff, 32'h80000000, '0);
      queue_cmd(CMD_EVAL, '0, '0, T_W'(0));
      queue_cmd(CMD_APPEND, 32'h80000000, 32'h7fffffff, '0);
      queue_cmd(CMD_EVAL, '0, '0, T_W'(65536));
      queue_cmd(CMD_EVAL, '0, '0, 18'h20000);
      queue_cmd(CMD_EVAL, '0, '0, 18'h1ffff);
      queue_cmd(CMD_APPEND, 32'h00010000, 32'hffff0000, '0);
      queue_cmd(CMD_EVAL, '0, '0, T_W'(21845));
      queue_cmd(CMD_NOP, 32'hffffffff, 32'hffffffff, 18'h3ffff);
      queue_points(NPTS);
      queue_cmd(CMD_EVAL, '0, '0, T_W'(40000));
      queue_cmd(CMD_CLEAR, '0, '0, '0);
      queue_cmd(CMD_EVAL, '0, '0, T_W'(1));
      wait_drained();
      // sender pause and long receiver hold-off while the queue keeps filling
      hold_request = 300;
      queue_cmd(CMD_CLEAR, '0, '0, '0);
      queue_points(8);
      queue_cmd(CMD_EVAL, '0, '0, rand_t());
      wait_drained();
      sent = 0;
      while (sent < 1200) begin
         int k;
         k = $urandom_range(0, 9);
         if (k == 0) begin
            queue_cmd(CMD_CLEAR, rand_coord(), rand_coord(), rand_t()); sent++;
         end else if (k == 1) begin
            queue_cmd(CMD_NOP, rand_coord(), rand_coord(), rand_t()); sent++;
         end else if (k < 5) begin
            queue_cmd(CMD_APPEND, rand_coord(), rand_coord(), rand_t()); sent++;
         end else begin
            queue_cmd(CMD_EVAL, rand_coord(), rand_coord(), rand_t()); sent++;
         end
         if (sent % 100 == 0) wait_drained();
         while (pending_cmds.size() > 4) @(posedge clock);
      end
      wait_drained();
      repeat (200) @(posedge clock);
      if (mismatches == 0 && expected_curves.size() == 0) $display("tb_top: PASS");
      else $display("tb_top: FAIL");
      $finish;
   end

endmodule
